>>> rtl/core/aaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aaf_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int CORDIC_STAGES = 20;
  localparam int GUARD_SHIFT   = 58 - COORD_WIDTH;
  localparam int DW            = 64;  // CORDIC x/y datapath
  localparam int ZW            = 36;  // angle accumulator, degrees Q24
  localparam int YAW_W         = 25;
  localparam int PITCH_W       = 24;
  localparam int RND_SHIFT     = 8;   // Q24 -> Q16

  localparam logic signed [ZW-1:0] DEG_90  = ZW'(64'sd1509949440);
  localparam logic signed [ZW-1:0] DEG_180 = ZW'(64'sd3019898880);
  localparam logic signed [ZW-1:0] DEG_360 = ZW'(64'sd6039797760);
  localparam logic signed [ZW-1:0] RND_HALF = ZW'(64'sd128);

  // 1/K of the CORDIC in Q30
  localparam logic [29:0] INV_GAIN = 30'd652032874;

  // atan(2^-i) in degrees, Q24
  function automatic logic signed [ZW-1:0] atan_deg(input int idx);
    logic [31:0] v;
    unique case (idx)
      0: v = 32'd754974720;   1: v = 32'd445687602;  2: v = 32'd235489088;
      3: v = 32'd119537938;   4: v = 32'd60000934;   5: v = 32'd30029717;
      6: v = 32'd15018523;    7: v = 32'd7509720;    8: v = 32'd3754917;
      9: v = 32'd1877466;    10: v = 32'd938734;    11: v = 32'd469367;
      12: v = 32'd234684;    13: v = 32'd117342;    14: v = 32'd58671;
      15: v = 32'd29335;     16: v = 32'd14668;     17: v = 32'd7334;
      18: v = 32'd3667;      19: v = 32'd1833;      20: v = 32'd917;
      21: v = 32'd458;       22: v = 32'd229;       23: v = 32'd115;
      24: v = 32'd57;        25: v = 32'd29;        26: v = 32'd14;
      27: v = 32'd7;         28: v = 32'd4;         29: v = 32'd2;
      default: v = 32'd0;
    endcase
    return ZW'(v);
  endfunction

  // side info that rides along with each point pair
  typedef struct packed {
    logic                    deg;    // all three deltas zero
    logic                    dz0;    // dz zero
    logic                    dzpos;  // dz positive
    logic [COORD_WIDTH:0]    mz;     // |dz|
    logic signed [ZW-1:0]    yaw;    // base angle, then final yaw Q24
  } meta_t;

endpackage
`default_nettype wire

>>> rtl/core/aaf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface aaf_in_if;
  import aaf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] src_x;
  logic [COORD_WIDTH-1:0] src_y;
  logic [COORD_WIDTH-1:0] src_z;
  logic [COORD_WIDTH-1:0] dst_x;
  logic [COORD_WIDTH-1:0] dst_y;
  logic [COORD_WIDTH-1:0] dst_z;
  modport source (output valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, input ready);
  modport sink   (input valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, output ready);
endinterface
`default_nettype wire

>>> rtl/core/aaf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface aaf_out_if;
  import aaf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [YAW_W-1:0]          yaw_deg;
  logic signed [PITCH_W-1:0] pitch_deg;
  logic                      degenerate;
  modport source (output valid, yaw_deg, pitch_deg, degenerate, input ready);
  modport sink   (input valid, yaw_deg, pitch_deg, degenerate, output ready);
endinterface
`default_nettype wire

>>> rtl/core/aim_angles_from_points_core.sv
// Aim angles from a source point toward a destination point.
// in_pt  : one beat carries src_x/y/z and dst_x/y/z, signed Q16.8.
// out_ang: one beat carries yaw_deg (0..360, Q16), pitch_deg (-90..90, Q16)
//          and degenerate (source equals destination, angles forced to 0).
// Stages in order: delta, yaw setup, the yaw vectoring CORDIC, a 1/K gain
// multiply, pitch setup, the pitch vectoring CORDIC and the output register.
// Throughput is one beat per cycle while the receiver keeps up; every CORDIC iteration is its own stage.
// Reset clears all stage valid bits and the output valid; the payload
// registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_pt.ready drops; nothing is lost or repeated. An empty output
// register never stalls the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module aim_angles_from_points_core
  import aaf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  aaf_in_if.sink      in_pt,
  aaf_out_if.source   out_ang
);

  localparam int N  = CORDIC_STAGES;
  localparam int CW = COORD_WIDTH;

  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_ang.ready;
  assign in_pt.ready = en;

  // ---------------- stage 0: deltas ----------------
  logic signed [CW:0] dx_r, dy_r, dz_r;
  logic signed [CW:0] dx_nxt, dy_nxt, dz_nxt;
  logic               v0_r;

  assign dx_nxt = $signed({in_pt.src_x[CW-1], in_pt.src_x})
                - $signed({in_pt.dst_x[CW-1], in_pt.dst_x});
  assign dy_nxt = $signed({in_pt.src_y[CW-1], in_pt.src_y})
                - $signed({in_pt.dst_y[CW-1], in_pt.dst_y});
  assign dz_nxt = $signed({in_pt.src_z[CW-1], in_pt.src_z})
                - $signed({in_pt.dst_z[CW-1], in_pt.dst_z});

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
  end

  // ---------------- yaw CORDIC storage ----------------
  logic signed [DW-1:0] yx_r [0:N];
  logic signed [DW-1:0] yy_r [0:N];
  logic signed [ZW-1:0] yz_r [0:N];
  logic                 ysk_r [0:N];
  meta_t                ym_r [0:N];
  logic [N:0]           yv_r;

  // ---------------- stage 1: yaw setup ----------------
  logic signed [DW-1:0] vxa, vya, vx_nxt, vy_nxt;
  logic signed [ZW-1:0] base_nxt;
  logic                 hz;
  meta_t                m1_nxt;

  always_comb begin
    vxa = -(DW'(dy_r) <<< GUARD_SHIFT);
    vya = DW'(dx_r) <<< GUARD_SHIFT;
    hz  = (dx_r == '0) && (dy_r == '0);
    if (vxa[DW-1]) begin
      base_nxt = vya[DW-1] ? -DEG_180 : DEG_180;
      vx_nxt   = -vxa;
      vy_nxt   = -vya;
    end else begin
      base_nxt = '0;
      vx_nxt   = vxa;
      vy_nxt   = vya;
    end
    // no horizontal delta: yaw lands on 360
    if (hz) begin
      base_nxt = DEG_180;
    end
    m1_nxt.deg   = hz && (dz_r == '0);
    m1_nxt.dz0   = (dz_r == '0);
    m1_nxt.dzpos = !dz_r[CW] && (dz_r != '0);
    m1_nxt.mz    = dz_r[CW] ? unsigned'(-dz_r) : unsigned'(dz_r);
    m1_nxt.yaw   = base_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yx_r[0]  <= vx_nxt;
      yy_r[0]  <= vy_nxt;
      yz_r[0]  <= '0;
      ysk_r[0] <= (vy_nxt == '0);
      ym_r[0]  <= m1_nxt;
    end
  end

  // ---------------- yaw CORDIC iterations ----------------
  for (genvar i = 0; i < N; i++) begin : g_yaw
    logic signed [DW-1:0] x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;
    always_comb begin
      x_nxt = yx_r[i];
      y_nxt = yy_r[i];
      z_nxt = yz_r[i];
      if (!ysk_r[i]) begin
        if (yy_r[i][DW-1]) begin
          x_nxt = yx_r[i] - (yy_r[i] >>> i);
          y_nxt = yy_r[i] + (yx_r[i] >>> i);
          z_nxt = yz_r[i] - atan_deg(i);
        end else begin
          x_nxt = yx_r[i] + (yy_r[i] >>> i);
          y_nxt = yy_r[i] - (yx_r[i] >>> i);
          z_nxt = yz_r[i] + atan_deg(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        yx_r[i+1]  <= x_nxt;
        yy_r[i+1]  <= y_nxt;
        yz_r[i+1]  <= z_nxt;
        ysk_r[i+1] <= ysk_r[i];
        ym_r[i+1]  <= ym_r[i];
      end
    end
  end

  // ---------------- gain: partial products of x * 1/K ----------------
  logic [61:0]          ph_r, pl_r;
  logic signed [DW-1:0] gx_r;
  logic                 gsk_r, gv_r;
  meta_t                gm_r;
  meta_t                gm_nxt;

  always_comb begin
    gm_nxt     = ym_r[N];
    gm_nxt.yaw = ym_r[N].yaw + yz_r[N] + DEG_180;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r  <= 62'(yx_r[N][DW-1:32]) * 62'(INV_GAIN);
      pl_r  <= 62'(yx_r[N][31:0]) * 62'(INV_GAIN);
      gx_r  <= yx_r[N];
      gsk_r <= ysk_r[N];
      gm_r  <= gm_nxt;
    end
  end

  // ---------------- pitch CORDIC storage ----------------
  logic signed [DW-1:0] px_r [0:N];
  logic signed [DW-1:0] py_r [0:N];
  logic signed [ZW-1:0] pz_r [0:N];
  logic                 psk_r [0:N];
  meta_t                pm_r [0:N];
  logic [N:0]           pv_r;

  // ---------------- pitch setup: sum of products, special cases ----------------
  logic [DW-1:0] r_nxt;
  logic          r0;

  always_comb begin
    r_nxt = gsk_r ? unsigned'(gx_r) : ((DW'(ph_r) << 2) + DW'(pl_r >> 30));
    r0    = (r_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0]  <= signed'(r_nxt);
      py_r[0]  <= signed'(DW'(gm_r.mz) << GUARD_SHIFT);
      pz_r[0]  <= (r0 && !gm_r.dz0) ? DEG_90 : '0;
      psk_r[0] <= gm_r.dz0 || r0;
      pm_r[0]  <= gm_r;
    end
  end

  // ---------------- pitch CORDIC iterations ----------------
  for (genvar i = 0; i < N; i++) begin : g_pitch
    logic signed [DW-1:0] x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;
    always_comb begin
      x_nxt = px_r[i];
      y_nxt = py_r[i];
      z_nxt = pz_r[i];
      if (!psk_r[i]) begin
        if (py_r[i][DW-1]) begin
          x_nxt = px_r[i] - (py_r[i] >>> i);
          y_nxt = py_r[i] + (px_r[i] >>> i);
          z_nxt = pz_r[i] - atan_deg(i);
        end else begin
          x_nxt = px_r[i] + (py_r[i] >>> i);
          y_nxt = py_r[i] - (px_r[i] >>> i);
          z_nxt = pz_r[i] + atan_deg(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        px_r[i+1]  <= x_nxt;
        py_r[i+1]  <= y_nxt;
        pz_r[i+1]  <= z_nxt;
        psk_r[i+1] <= psk_r[i];
        pm_r[i+1]  <= pm_r[i];
      end
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      yv_r        <= '0;
      gv_r        <= 1'b0;
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= in_pt.valid;
      yv_r        <= {yv_r[N-1:0], v0_r};
      gv_r        <= yv_r[N];
      pv_r        <= {pv_r[N-1:0], gv_r};
      out_valid_r <= pv_r[N];
    end
  end

  // ---------------- clamp, round, output register ----------------
  logic signed [ZW-1:0]      yc, pc, pa, yrnd, prnd;
  logic [YAW_W-1:0]          yaw_nxt, yaw_r;
  logic signed [PITCH_W-1:0] pitch_nxt, pitch_r;
  logic                      deg_r;

  always_comb begin
    yc = pm_r[N].yaw;
    if (yc < 0) begin
      yc = '0;
    end else if (yc > DEG_360) begin
      yc = DEG_360;
    end
    pa = pm_r[N].dzpos ? -pz_r[N] : pz_r[N];
    pc = pa;
    if (pa < -DEG_90) begin
      pc = -DEG_90;
    end else if (pa > DEG_90) begin
      pc = DEG_90;
    end
    yrnd = (yc + RND_HALF) >>> RND_SHIFT;
    prnd = (pc + RND_HALF) >>> RND_SHIFT;
    if (pm_r[N].deg) begin
      yaw_nxt   = '0;
      pitch_nxt = '0;
    end else begin
      yaw_nxt   = yrnd[YAW_W-1:0];
      pitch_nxt = prnd[PITCH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
      deg_r   <= pm_r[N].deg;
    end
  end

  assign out_ang.valid      = out_valid_r;
  assign out_ang.yaw_deg    = yaw_r;
  assign out_ang.pitch_deg  = pitch_r;
  assign out_ang.degenerate = deg_r;

`ifndef SYNTHESIS
  // a degenerate beat carries zero angles
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ang.valid && out_ang.degenerate |-> out_ang.yaw_deg == '0 && out_ang.pitch_deg == '0)
    else $error("degenerate beat with nonzero angles");

  // yaw and pitch stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ang.valid |-> out_ang.yaw_deg <= YAW_W'(23592960)
      && out_ang.pitch_deg <= 24'sd5898240 && out_ang.pitch_deg >= -24'sd5898240)
    else $error("angle out of range");

  // an empty output register never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ang.valid |-> in_pt.ready)
    else $error("input stalled with empty output");
`endif

endmodule
`default_nettype wire
